/* rtl/nalsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NAL splitter package
// Shared types and constants for the Annex-B NAL unit splitter.
// ----------------------------------------------------------------------------
package nalsp_pkg;

  localparam logic [7:0] START_BYTE = 8'h01;
  localparam logic [7:0] EPB_BYTE   = 8'h03;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;

  // Command queue between the front and back ends.
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // One command: commit zero_cnt held zeros, then optionally the byte itself,
  // then optionally close the NAL unit. The header travels with the command.
  typedef struct packed {
    logic [7:0]  data;
    logic [1:0]  zero_cnt;
    logic        commit_data;
    logic        finish;
    logic [15:0] header;
  } cmd_t;

  typedef struct packed {
    logic                 empty;
    logic                 full;
    logic [CMD_CNT_W-1:0] count;
  } queue_stat_t;

  typedef struct packed {
    logic [7:0] rbsp_byte;
    logic [5:0] nal_type;
    logic [5:0] nuh_layer;
    logic [2:0] tid_plus1;
    logic       forbidden_bit;
    logic       first_of_nal;
    logic       last_of_nal;
  } out_item_t;

endpackage

/* rtl/nalsp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NAL splitter front end
// Finds start codes, captures the NAL header, counts held-back zeros and
// turns accepted bytes into commit commands for the back end.
// ----------------------------------------------------------------------------
module nalsp_front
  import nalsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_buffer,
  output logic       cmd_push,
  output cmd_t       cmd
);

  logic        in_nal_r, in_nal_nxt;
  logic [1:0]  run_r, run_nxt;
  logic [15:0] header_r, header_nxt;
  logic [1:0]  nal_len_r, nal_len_nxt;
  logic [1:0]  held_r, held_nxt;

  logic       is_zero;
  logic [1:0] run_sat;
  logic       end_start;

  assign is_zero   = (data_byte == ZERO_BYTE);
  assign run_sat   = is_zero ? ((run_r == 2'd3) ? 2'd3 : run_r + 2'd1) : 2'd0;
  assign end_start = in_nal_r && (data_byte == START_BYTE) && (nal_len_r == 2'd3)
                     && (run_r >= 2'd2);

  always_comb begin
    in_nal_nxt       = in_nal_r;
    run_nxt          = run_r;
    header_nxt       = header_r;
    nal_len_nxt      = nal_len_r;
    held_nxt         = held_r;
    cmd.data         = data_byte;
    cmd.zero_cnt     = 2'd0;
    cmd.commit_data  = 1'b0;
    cmd.finish       = 1'b0;
    cmd.header       = header_r;

    if (!in_nal_r) begin
      if ((data_byte == START_BYTE) && (run_r >= 2'd2)) begin
        in_nal_nxt  = 1'b1;
        run_nxt     = 2'd0;
        header_nxt  = 16'd0;
        nal_len_nxt = 2'd0;
        held_nxt    = 2'd0;
      end else begin
        run_nxt = run_sat;
      end
    end else if (end_start) begin
      // Two start-code zeros are dropped, and a third one before them too.
      if ((held_r == 2'd3) && (run_r == 2'd2)) begin
        cmd.zero_cnt = 2'd1;
      end
      cmd.finish  = 1'b1;
      run_nxt     = 2'd0;
      header_nxt  = 16'd0;
      nal_len_nxt = 2'd0;
      held_nxt    = 2'd0;
    end else begin
      case (nal_len_r)
        2'd0: begin
          header_nxt = {data_byte, header_r[7:0]};
        end
        2'd1: begin
          header_nxt = {header_r[15:8], data_byte};
        end
        default: begin
          if (is_zero) begin
            if (end_of_buffer) begin
              cmd.zero_cnt    = held_r;
              cmd.commit_data = 1'b1;
            end else if (held_r == 2'd3) begin
              cmd.zero_cnt = 2'd1;
            end else begin
              held_nxt = held_r + 2'd1;
            end
          end else begin
            cmd.zero_cnt    = held_r;
            cmd.commit_data = 1'b1;
            held_nxt        = 2'd0;
          end
        end
      endcase
      if (end_of_buffer) begin
        cmd.finish = 1'b1;
      end
      run_nxt     = run_sat;
      nal_len_nxt = (nal_len_r == 2'd3) ? 2'd3 : nal_len_r + 2'd1;
    end

    if (end_of_buffer) begin
      in_nal_nxt  = 1'b0;
      run_nxt     = 2'd0;
      header_nxt  = 16'd0;
      nal_len_nxt = 2'd0;
      held_nxt    = 2'd0;
    end
  end

  assign cmd_push = accept && ((cmd.zero_cnt != 2'd0) || cmd.commit_data || cmd.finish);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_nal_r  <= 1'b0;
      run_r     <= 2'd0;
      header_r  <= 16'd0;
      nal_len_r <= 2'd0;
      held_r    <= 2'd0;
    end else if (accept) begin
      in_nal_r  <= in_nal_nxt;
      run_r     <= run_nxt;
      header_r  <= header_nxt;
      nal_len_r <= nal_len_nxt;
      held_r    <= held_nxt;
    end
  end

endmodule

/* rtl/nalsp_cmd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NAL splitter command queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module nalsp_cmd_queue
  import nalsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  cmd_t        push_cmd,
  input  logic        pop,
  output cmd_t        head,
  output queue_stat_t stat
);

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r;
  logic [CMD_PTR_W-1:0] rd_ptr_r;
  logic [CMD_CNT_W-1:0] count_r;
  logic                 do_push;
  logic                 do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CMD_CNT_W'(CMD_DEPTH));
  assign stat.count = count_r;
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CMD_CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/nalsp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NAL splitter back end
// Steps through commands one commit per cycle while the result FIFO has room,
// removes emulation prevention bytes, marks first and last bytes and fills it.
// ----------------------------------------------------------------------------
module nalsp_back
  import nalsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  logic [2:0] step_r;
  logic [1:0] epb_run_r;
  logic       pend_valid_r;
  logic [7:0] pend_byte_r;
  logic       first_r;

  out_item_t  fifo_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fifo_cnt_r;

  logic [2:0] total_ops;
  logic       op_zero;
  logic       op_data;
  logic       op_finish;
  logic       last_op;
  logic [7:0] commit_val;
  logic       epb_skip;
  logic       space;
  logic       step;
  logic       emit;
  logic       pop_fire;
  out_item_t  new_item;

  assign total_ops  = {1'b0, cmd.zero_cnt} + {2'b00, cmd.commit_data} + {2'b00, cmd.finish};
  assign op_zero    = (step_r < {1'b0, cmd.zero_cnt});
  assign op_data    = !op_zero && cmd.commit_data && (step_r == {1'b0, cmd.zero_cnt});
  assign op_finish  = !op_zero && !op_data;
  assign last_op    = ((step_r + 3'd1) == total_ops);
  assign commit_val = op_zero ? ZERO_BYTE : cmd.data;
  assign epb_skip   = (epb_run_r == 2'd2) && (commit_val == EPB_BYTE);

  assign pop_fire = out_pop && (fifo_cnt_r != 2'd0);
  assign space    = (fifo_cnt_r != 2'd2) || out_pop;
  assign step     = cmd_valid && space;
  assign cmd_pop  = step && last_op;
  assign emit     = step && pend_valid_r && (op_finish || !epb_skip);

  always_comb begin
    new_item.rbsp_byte     = pend_byte_r;
    new_item.nal_type      = cmd.header[14:9];
    new_item.nuh_layer     = {cmd.header[8], cmd.header[7:3]};
    new_item.tid_plus1     = cmd.header[2:0];
    new_item.forbidden_bit = cmd.header[15];
    new_item.first_of_nal  = first_r;
    new_item.last_of_nal   = op_finish;
  end

  assign out_empty = (fifo_cnt_r == 2'd0);
  assign out_item  = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (emit) begin
      fifo_r[wr_ptr_r] <= new_item;
    end
    if (step && !op_finish && !epb_skip) begin
      pend_byte_r <= commit_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= 3'd0;
      epb_run_r    <= 2'd0;
      pend_valid_r <= 1'b0;
      first_r      <= 1'b1;
      wr_ptr_r     <= 1'b0;
      rd_ptr_r     <= 1'b0;
      fifo_cnt_r   <= 2'd0;
    end else begin
      if (step) begin
        step_r <= last_op ? 3'd0 : step_r + 3'd1;
        if (op_finish) begin
          epb_run_r    <= 2'd0;
          pend_valid_r <= 1'b0;
          first_r      <= 1'b1;
        end else if (epb_skip) begin
          epb_run_r <= 2'd0;
        end else begin
          if (commit_val == ZERO_BYTE) begin
            epb_run_r <= (epb_run_r == 2'd2) ? 2'd2 : epb_run_r + 2'd1;
          end else begin
            epb_run_r <= 2'd0;
          end
          pend_valid_r <= 1'b1;
          if (pend_valid_r) begin
            first_r <= 1'b0;
          end
        end
      end
      if (emit) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_fire) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (emit && !pop_fire) begin
        fifo_cnt_r <= fifo_cnt_r + 2'd1;
      end else if (pop_fire && !emit) begin
        fifo_cnt_r <= fifo_cnt_r - 2'd1;
      end
    end
  end

endmodule

/* rtl/hevc_annexb_nal_splitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HEVC Annex-B NAL splitter
// Splits an Annex-B byte stream into NAL units and emits RBSP bytes with
// the decoded NAL header fields and first/last marks.
// ----------------------------------------------------------------------------
// Usage:
//   Input is a queue-style channel: drive in_data_byte and in_end_of_buffer
//   and raise in_push; the byte is taken on a clock edge where in_full is low.
//   Raise in_end_of_buffer on the last byte of a buffer to flush the current
//   NAL unit and return to start-code search.
//   Results come out of a second queue: while out_empty is low the oldest
//   RBSP byte and its header fields sit on the out_ ports; out_pop takes it.
// Throughput: one byte per cycle while in_full is low. Each request becomes at
//   most one command of one to five commits; the back end executes one commit
//   per cycle while the result queue has room.
// Every RBSP byte is held in the back end until the next surviving byte
//   (or the end of its NAL unit) is committed, so that its last mark is known,
//   and only then written to the result queue.
// Reset (rst_n low, synchronous) empties both queues and returns to search.
// When the receiver stalls, the result queue fills, the back end stops, the
//   four-entry command queue fills and in_full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module hevc_annexb_nal_splitter
  import nalsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_buffer,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_rbsp_byte,
  output logic [5:0] out_nal_type,
  output logic [5:0] out_nuh_layer,
  output logic [2:0] out_tid_plus1,
  output logic       out_forbidden_bit,
  output logic       out_first_of_nal,
  output logic       out_last_of_nal
);

  logic        accept;
  logic        cmd_push;
  cmd_t        front_cmd;
  cmd_t        head_cmd;
  logic        cmd_pop;
  queue_stat_t q_stat;
  out_item_t   item;

  // The front end only advances when the command queue can take a request.
  assign in_full = q_stat.full;
  assign accept  = in_push && !in_full;

  nalsp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_data_byte),
    .end_of_buffer (in_end_of_buffer),
    .cmd_push      (cmd_push),
    .cmd           (front_cmd)
  );

  nalsp_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (front_cmd),
    .pop      (cmd_pop),
    .head     (head_cmd),
    .stat     (q_stat)
  );

  nalsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_stat.empty),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (item)
  );

  assign out_rbsp_byte     = item.rbsp_byte;
  assign out_nal_type      = item.nal_type;
  assign out_nuh_layer     = item.nuh_layer;
  assign out_tid_plus1     = item.tid_plus1;
  assign out_forbidden_bit = item.forbidden_bit;
  assign out_first_of_nal  = item.first_of_nal;
  assign out_last_of_nal   = item.last_of_nal;

  // A command must never be produced while the queue has no room for it.
  assert property (@(posedge clk) disable iff (!rst_n) !(cmd_push && q_stat.full))
    else $error("command pushed into a full queue");

  // The back end only consumes commands that are present.
  assert property (@(posedge clk) disable iff (!rst_n) !(cmd_pop && q_stat.empty))
    else $error("command popped from an empty queue");

  // After reset both sides start empty and ready.
  assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("queues not cleared by reset");

endmodule
